>>> design/assert_macros.svh
// Assertion macros used by the checker file of the episode detector.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> design/hed_pkg.sv
// Package for the hypoglycemia episode detector: payload types, register
// indexes, constants and the saturating counter helper. No dependencies.
package hed_pkg;

    localparam int unsigned MAX_SEGMENT_SAMPLES = 65536;
    localparam int unsigned GLU_W  = 14;
    localparam int unsigned IDX_W  = 16;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // 54.0 mg/dL in tenths of mg/dL.
    localparam logic [GLU_W-1:0] SEVERE_LEVEL = GLU_W'(540);

    localparam logic [GLU_W-1:0] RST_LOW_THRESHOLD      = GLU_W'(700);
    localparam logic [CNT_W-1:0] RST_MIN_LOW_COUNT      = CNT_W'(24);
    localparam logic [CNT_W-1:0] RST_MIN_RECOVERY_COUNT = CNT_W'(3);

    // Last index before the segment index wraps to zero.
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MAX_SEGMENT_SAMPLES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_THRESHOLD      = 2'd0,
        CFG_MIN_LOW_COUNT      = 2'd1,
        CFG_MIN_RECOVERY_COUNT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [GLU_W-1:0] glucose;
        logic             sample_valid;
        logic             segment_end;
    } t_item_in;

    typedef struct packed {
        logic [IDX_W-1:0] first_low_index;
        logic [IDX_W-1:0] last_low_index;
        logic [IDX_W-1:0] confirm_index;
        logic [CNT_W-1:0] severe_count;
        logic             by_recovery;
    } t_item_out;

    // Adds a to b and sticks at the counter maximum.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

>>> design/hypoglycemia_episode_detector_core.sv
// Hypoglycemia episode detector: one glucose sample per input transaction,
// at most one episode report per output transaction. Uses hed_pkg.
//
// Input channel (i_valid / o_ready, payload i_item): one sample with its valid
// and segment-end flags. Output channel (o_valid / i_ready, payload o_result):
// an episode report with first-low, last-low and confirm indices, the severe
// reading count, and whether recovery confirmed it.
// An accepted sample sits in the input register, is evaluated against the
// episode state once the result register is free or its report is taken,
// and its report is loaded into the result register at the end of that
// evaluation cycle. One sample is taken every cycle while the receiver keeps
// up; the single evaluation stage only compares and updates counters.
// When the receiver stalls with a report pending, the evaluation stage holds;
// the input register still accepts one more sample, then o_ready drops until
// the report is taken.
// Reset (synchronous, active low) empties both registers, clears the episode
// state and the segment index, and loads threshold 700, minimum low count 24
// and minimum recovery count 3. Configuration writes (i_cfg_wr_en, i_cfg_index,
// i_cfg_wr_data) take effect at once and are meant for when the block is idle.
module hypoglycemia_episode_detector_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hed_pkg::t_item_in                   i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output hed_pkg::t_item_out                  o_result,
    input  logic                                i_cfg_wr_en,
    input  logic [hed_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hed_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data
);

    // Configuration registers.
    logic [hed_pkg::GLU_W-1:0] r_low_threshold;
    logic [hed_pkg::CNT_W-1:0] r_min_low_count;
    logic [hed_pkg::CNT_W-1:0] r_min_recovery_count;

    // Input register.
    logic              r_in_vld;
    hed_pkg::t_item_in r_in;

    // Episode state.
    logic                      r_in_episode;
    logic [hed_pkg::IDX_W-1:0] r_sample_index;
    logic [hed_pkg::IDX_W-1:0] r_episode_start;
    logic [hed_pkg::IDX_W-1:0] r_last_low_index;
    logic [hed_pkg::CNT_W-1:0] r_low_count;
    logic [hed_pkg::CNT_W-1:0] r_recovery_count;
    logic [hed_pkg::CNT_W-1:0] r_severe_committed;
    logic [hed_pkg::CNT_W-1:0] r_severe_pending;

    // Result register.
    logic               r_out_vld;
    hed_pkg::t_item_out r_out;

    // Next values.
    logic                      n_in_episode;
    logic [hed_pkg::IDX_W-1:0] n_sample_index;
    logic [hed_pkg::IDX_W-1:0] n_episode_start;
    logic [hed_pkg::IDX_W-1:0] n_last_low_index;
    logic [hed_pkg::CNT_W-1:0] n_low_count;
    logic [hed_pkg::CNT_W-1:0] n_recovery_count;
    logic [hed_pkg::CNT_W-1:0] n_severe_committed;
    logic [hed_pkg::CNT_W-1:0] n_severe_pending;
    logic                      n_emit;
    hed_pkg::t_item_out        n_out;

    logic eval_fire;
    logic in_fire;

    assign eval_fire = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready   = !r_in_vld || eval_fire;
    assign in_fire   = i_valid && o_ready;
    assign o_valid   = r_out_vld;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_threshold      <= hed_pkg::RST_LOW_THRESHOLD;
            r_min_low_count      <= hed_pkg::RST_MIN_LOW_COUNT;
            r_min_recovery_count <= hed_pkg::RST_MIN_RECOVERY_COUNT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                hed_pkg::CFG_LOW_THRESHOLD:
                    r_low_threshold <= i_cfg_wr_data[hed_pkg::GLU_W-1:0];
                hed_pkg::CFG_MIN_LOW_COUNT:
                    r_min_low_count <= i_cfg_wr_data;
                hed_pkg::CFG_MIN_RECOVERY_COUNT:
                    r_min_recovery_count <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic low;
        logic [hed_pkg::CNT_W-1:0] sev;
        logic [hed_pkg::IDX_W-1:0] idx;

        idx  = r_sample_index;
        low  = r_in.glucose < r_low_threshold;
        sev  = hed_pkg::CNT_W'(r_in.glucose < hed_pkg::SEVERE_LEVEL);

        n_in_episode       = r_in_episode;
        n_episode_start    = r_episode_start;
        n_last_low_index   = r_last_low_index;
        n_low_count        = r_low_count;
        n_recovery_count   = r_recovery_count;
        n_severe_committed = r_severe_committed;
        n_severe_pending   = r_severe_pending;
        n_emit             = 1'b0;
        n_out              = '0;

        if (r_in.sample_valid) begin
            if (!r_in_episode) begin
                if (low) begin
                    n_in_episode       = 1'b1;
                    n_episode_start    = idx;
                    n_last_low_index   = idx;
                    n_low_count        = hed_pkg::CNT_W'(1);
                    n_recovery_count   = '0;
                    n_severe_committed = sev;
                    n_severe_pending   = '0;
                end
            end else if (low) begin
                n_low_count        = hed_pkg::sat_add(r_low_count, hed_pkg::CNT_W'(1));
                n_last_low_index   = idx;
                n_recovery_count   = '0;
                // Severe readings seen during a recovery attempt count only
                // once a new low reading shows the episode went on.
                n_severe_committed = hed_pkg::sat_add(
                    hed_pkg::sat_add(r_severe_committed, r_severe_pending), sev);
                n_severe_pending   = '0;
            end else if (r_low_count < r_min_low_count) begin
                n_in_episode = 1'b0;
            end else begin
                n_recovery_count = hed_pkg::sat_add(r_recovery_count, hed_pkg::CNT_W'(1));
                n_severe_pending = hed_pkg::sat_add(r_severe_pending, sev);
                if (n_recovery_count >= r_min_recovery_count) begin
                    n_emit                = 1'b1;
                    n_out.first_low_index = r_episode_start;
                    n_out.last_low_index  = r_last_low_index;
                    n_out.confirm_index   = idx;
                    n_out.severe_count    = r_severe_committed;
                    n_out.by_recovery     = 1'b1;
                    n_in_episode          = 1'b0;
                end
            end
        end

        // A segment end flushes a qualifying open episode; an episode that
        // just closed by recovery on this sample is not reported twice.
        if (r_in.segment_end) begin
            if (n_in_episode && n_low_count >= r_min_low_count) begin
                n_emit                = 1'b1;
                n_out.first_low_index = n_episode_start;
                n_out.last_low_index  = n_last_low_index;
                n_out.confirm_index   = idx;
                n_out.severe_count    = n_severe_committed;
                n_out.by_recovery     = 1'b0;
            end
            n_in_episode   = 1'b0;
            n_sample_index = '0;
        end else begin
            n_sample_index = (idx == hed_pkg::LAST_INDEX) ? '0 : idx + hed_pkg::IDX_W'(1);
        end

        if (!n_in_episode) begin
            n_episode_start    = '0;
            n_last_low_index   = '0;
            n_low_count        = '0;
            n_recovery_count   = '0;
            n_severe_committed = '0;
            n_severe_pending   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld           <= 1'b0;
            r_out_vld          <= 1'b0;
            r_in_episode       <= 1'b0;
            r_sample_index     <= '0;
            r_episode_start    <= '0;
            r_last_low_index   <= '0;
            r_low_count        <= '0;
            r_recovery_count   <= '0;
            r_severe_committed <= '0;
            r_severe_pending   <= '0;
        end else begin
            if (in_fire) begin
                r_in_vld <= 1'b1;
            end else if (eval_fire) begin
                r_in_vld <= 1'b0;
            end

            if (eval_fire) begin
                r_out_vld          <= n_emit;
                r_in_episode       <= n_in_episode;
                r_sample_index     <= n_sample_index;
                r_episode_start    <= n_episode_start;
                r_last_low_index   <= n_last_low_index;
                r_low_count        <= n_low_count;
                r_recovery_count   <= n_recovery_count;
                r_severe_committed <= n_severe_committed;
                r_severe_pending   <= n_severe_pending;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_item;
        end
        if (eval_fire) begin
            r_out <= n_out;
        end
    end

endmodule

>>> design/hed_checker.sv
// Port-level checker for the hypoglycemia episode detector, bound to the top
// level. Depends on hed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hed_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input hed_pkg::t_item_out o_result
);

    // A pending report stays put until the receiver takes it.
    `ASSERT_CLK(a_result_holds, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_result))

    // The input side only stalls when a report is waiting on a stalled receiver.
    `ASSERT_CLK(a_stall_cause, i_clk, i_rst_n, !o_ready |-> o_valid && !i_ready)

    // Right after reset no report is shown and a transaction can be taken.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !o_valid && o_ready)

endmodule

bind hypoglycemia_episode_detector_core hed_checker u_hed_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);
